>>> hw/rtl/gpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph page blitter package
// Shared types, register indexes and controller command constants.
// ----------------------------------------------------------------------------
package gpb_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_COLUMN = 2'd0,
		REG_START_ROW    = 2'd1,
		REG_GLYPH_WIDTH  = 2'd2,
		REG_GLYPH_HEIGHT = 2'd3
	} cfg_reg_t;

	// Register reset values.
	localparam logic [7:0] START_COLUMN_RST = 8'd0;
	localparam logic [5:0] START_ROW_RST    = 6'd0;
	localparam logic [5:0] GLYPH_WIDTH_RST  = 6'd5;
	localparam logic [5:0] GLYPH_HEIGHT_RST = 6'd8;

	// Controller command bytes.
	localparam logic [7:0] PAGE_CMD_LOW  = 8'hB6;
	localparam logic [7:0] PAGE_CMD_HIGH = 8'hAE;
	localparam logic [7:0] COL_HI_CMD    = 8'h10;

	// Configuration registers as seen by the front end.
	typedef struct packed {
		logic [7:0] start_column;
		logic [5:0] start_row;
		logic [5:0] glyph_width;
		logic [5:0] glyph_height;
	} cfg_t;

	// One classified glyph byte: up to two runs of four controller bytes.
	typedef struct packed {
		logic [7:0] page_cmd0;
		logic [7:0] page_cmd1;
		logic [7:0] col_hi;
		logic [7:0] col_lo;
		logic [7:0] data0;
		logic [7:0] data1;
		logic       has0;
		logic       has1;
	} job_t;

	// Position of a byte inside one run.
	typedef enum logic [1:0] {
		STEP_PAGE   = 2'd0,
		STEP_COL_HI = 2'd1,
		STEP_COL_LO = 2'd2,
		STEP_DATA   = 2'd3
	} run_step_t;

	// Page address command; the two lowest pages sit at the top of the code space.
	function automatic logic [7:0] page_cmd(input logic [3:0] page);
		logic [7:0] p8;
		p8 = {4'h0, page};
		return (page < 4'd2) ? (PAGE_CMD_LOW + p8) : (PAGE_CMD_HIGH + p8);
	endfunction

endpackage

>>> hw/rtl/gpb_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph page blitter stream interfaces
// Valid/ready channels for glyph bytes in and controller bytes out.
// ----------------------------------------------------------------------------
interface gpb_glyph_if;
	logic       valid;
	logic       ready;
	logic [7:0] glyph_byte;

	modport source (output valid, output glyph_byte, input ready);
	modport sink (input valid, input glyph_byte, output ready);
endinterface

interface gpb_lcd_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_data;
	logic       last;

	modport source (output valid, output out_byte, output is_data, output last, input ready);
	modport sink (input valid, input out_byte, input is_data, input last, output ready);
endinterface

>>> hw/rtl/gpb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph page blitter front end
// Tracks glyph position, keeps the row above, and builds one job per byte.
// ----------------------------------------------------------------------------
module gpb_front #(
	parameter int MAX_WIDTH  = 32,
	parameter int PAGE_COUNT = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	gpb_glyph_if.sink      glyph,
	input  gpb_pkg::cfg_t  cfg,
	input  logic           restart,
	output logic           job_valid,
	input  logic           job_ready,
	output gpb_pkg::job_t  job
);

	localparam int CIDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic [8:0] MAX_W9 = 9'(MAX_WIDTH);
	localparam logic [4:0] PAGE_LIM = 5'(PAGE_COUNT);

	logic [CIDX_W-1:0] col_idx_q;
	logic [2:0]        row_idx_q;

	logic [7:0] prev_mem [MAX_WIDTH];

	logic        valid_s1;
	logic [7:0]  cur_s1;
	logic [7:0]  prev_s1;
	logic [3:0]  page_s1;
	logic [7:0]  col_s1;
	logic [2:0]  shift_s1;
	logic        first_row_s1;
	logic        last_row_s1;

	logic              accept;
	logic [8:0]        eff_w;
	logic [3:0]        rows;
	logic              wrap;
	logic [CIDX_W-1:0] idx_eff;
	logic [2:0]        row_eff;
	logic [8:0]        col_ext;
	logic [8:0]        col_inc;
	logic [3:0]        page;
	logic [7:0]        col;
	logic              last_row;

	assign glyph.ready = !valid_s1 || job_ready;
	assign accept = glyph.valid && glyph.ready;

	// Effective width and row count after clamping.
	always_comb begin
		eff_w = (cfg.glyph_width == 6'd0) ? 9'd1 : {3'b000, cfg.glyph_width};
		if (eff_w > MAX_W9) begin
			eff_w = MAX_W9;
		end
		rows = 4'((7'({1'b0, cfg.glyph_height}) + 7'd7) >> 3);
		if (rows == 4'd0) begin
			rows = 4'd1;
		end
	end

	// Position of the incoming byte and its display address.
	always_comb begin
		wrap = (9'(col_idx_q) >= eff_w) || ({1'b0, row_idx_q} >= rows);
		idx_eff = wrap ? '0 : col_idx_q;
		row_eff = wrap ? 3'd0 : row_idx_q;
		col_ext = 9'(idx_eff);
		col_inc = col_ext + 9'd1;
		page = {1'b0, cfg.start_row[5:3]} + {1'b0, row_eff};
		col = 8'(9'(cfg.start_column) + col_ext);
		last_row = (({1'b0, row_eff} + 4'd1) == rows);
	end

	// Column and row counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_idx_q <= '0;
			row_idx_q <= '0;
		end else if (restart) begin
			col_idx_q <= '0;
			row_idx_q <= '0;
		end else if (accept) begin
			if (col_inc >= eff_w) begin
				col_idx_q <= '0;
				row_idx_q <= last_row ? 3'd0 : (row_eff + 3'd1);
			end else begin
				col_idx_q <= col_inc[CIDX_W-1:0];
				row_idx_q <= row_eff;
			end
		end
	end

	// Row store: read the byte above, then overwrite it with the current byte.
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_s1 <= prev_mem[idx_eff];
			prev_mem[idx_eff] <= glyph.glyph_byte;
		end
	end

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (job_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1 <= glyph.glyph_byte;
			page_s1 <= page;
			col_s1 <= col;
			shift_s1 <= cfg.start_row[2:0];
			first_row_s1 <= (row_eff == 3'd0);
			last_row_s1 <= last_row;
		end
	end

	// Build the job: merge with the row above and split into two pages.
	logic [4:0]  pg0;
	logic [4:0]  pg1;
	logic [7:0]  prev_byte;
	logic [15:0] cur_sh;
	logic [15:0] prev_sh;

	always_comb begin
		pg0 = {1'b0, page_s1};
		pg1 = pg0 + 5'd1;
		prev_byte = first_row_s1 ? 8'd0 : prev_s1;
		cur_sh = {8'd0, cur_s1} << shift_s1;
		prev_sh = {8'd0, prev_byte} << shift_s1;
		job.page_cmd0 = gpb_pkg::page_cmd(pg0[3:0]);
		job.page_cmd1 = gpb_pkg::page_cmd(pg1[3:0]);
		job.col_hi = gpb_pkg::COL_HI_CMD + {4'h0, col_s1[7:4]};
		job.col_lo = {4'h0, col_s1[3:0]};
		job.data0 = cur_sh[7:0] | prev_sh[15:8];
		job.data1 = cur_sh[15:8];
		job.has0 = (pg0 < PAGE_LIM);
		job.has1 = last_row_s1 && (shift_s1 != 3'd0) && (pg1 < PAGE_LIM);
	end

	assign job_valid = valid_s1;

endmodule

>>> hw/rtl/gpb_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph page blitter job queue
// Short FIFO that decouples the front end from the byte sequencer.
// ----------------------------------------------------------------------------
module gpb_job_fifo #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  gpb_pkg::job_t wr_job,
	output logic          rd_valid,
	input  logic          rd_pop,
	output gpb_pkg::job_t rd_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	gpb_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic push;
	logic pop;

	assign wr_ready = (count_q != FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign push = wr_valid && wr_ready;
	assign pop = rd_pop && rd_valid;
	assign rd_job = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : (wr_ptr_q + AW'(1));
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : (rd_ptr_q + AW'(1));
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> hw/rtl/gpb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph page blitter back end
// Sequences each job into controller words through an output register.
// ----------------------------------------------------------------------------
module gpb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  gpb_pkg::job_t head,
	output logic          head_pop,
	gpb_lcd_if.source     lcd
);

	logic                 run_q;
	gpb_pkg::run_step_t   step_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 is_data_q;
	logic                 last_q;

	logic                 load_ok;
	logic                 any_run;
	logic                 emit;
	logic                 run_eff;
	logic                 final_word;
	logic                 run_nxt;
	gpb_pkg::run_step_t   step_nxt;
	logic [7:0]           word;

	assign lcd.valid = out_valid_q;
	assign lcd.out_byte = out_byte_q;
	assign lcd.is_data = is_data_q;
	assign lcd.last = last_q;

	// Emit control; a job with both runs off screen is dropped at once.
	always_comb begin
		load_ok = !out_valid_q || lcd.ready;
		any_run = head.has0 || head.has1;
		emit = head_valid && any_run && load_ok;
		run_eff = run_q || !head.has0;
		final_word = (step_q == gpb_pkg::STEP_DATA) && (run_eff || !head.has1);
		head_pop = head_valid && (!any_run || (load_ok && final_word));
	end

	// Next sequencer position.
	always_comb begin
		run_nxt = run_q;
		step_nxt = step_q;
		if (emit) begin
			case (step_q)
				gpb_pkg::STEP_PAGE: begin
					step_nxt = gpb_pkg::STEP_COL_HI;
				end
				gpb_pkg::STEP_COL_HI: begin
					step_nxt = gpb_pkg::STEP_COL_LO;
				end
				gpb_pkg::STEP_COL_LO: begin
					step_nxt = gpb_pkg::STEP_DATA;
				end
				default: begin
					step_nxt = gpb_pkg::STEP_PAGE;
					run_nxt = !final_word;
				end
			endcase
		end
	end

	// Word selected for the current position.
	always_comb begin
		case (step_q)
			gpb_pkg::STEP_PAGE: begin
				word = run_eff ? head.page_cmd1 : head.page_cmd0;
			end
			gpb_pkg::STEP_COL_HI: begin
				word = head.col_hi;
			end
			gpb_pkg::STEP_COL_LO: begin
				word = head.col_lo;
			end
			default: begin
				word = run_eff ? head.data1 : head.data0;
			end
		endcase
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			step_q <= gpb_pkg::STEP_PAGE;
		end else begin
			run_q <= run_nxt;
			step_q <= step_nxt;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (lcd.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= word;
			is_data_q <= (step_q == gpb_pkg::STEP_DATA);
			last_q <= final_word;
		end
	end

endmodule

>>> hw/rtl/glyph_page_blitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph page blitter
// Streams glyph column bytes into command and data words for a page LCD.
// ----------------------------------------------------------------------------
// Usage:
// Glyph bytes enter on the glyph channel, row by row, glyph_width bytes to a
// row. For each byte the lcd channel carries one run of four words (page,
// column high, column low, data) and, on the last glyph row with a nonzero
// bit offset, a second run for the page below; runs for pages past the panel
// are dropped. The final word of a byte's output carries last.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while the
// block is idle; any write restarts the glyph at its first byte.
// The first word of a byte passes the front-end stage register, the job queue
// and the output register before it is presented on lcd. Throughput: one lcd
// word per cycle while the receiver is ready; a job with both runs dropped is
// popped without output; the sequencer sets the rate, and a two-entry job
// queue lets the front end take bytes while it works.
// Reset clears the glyph position, the queue and the output register; the
// row store needs no clearing since it is read only after being written.
// A stalled lcd receiver holds its word; once the queue fills, glyph.ready
// drops until the sequencer frees an entry.
// ----------------------------------------------------------------------------
module glyph_page_blitter_top #(
	parameter int MAX_WIDTH  = 32,
	parameter int PAGE_COUNT = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	gpb_glyph_if.sink                        glyph,
	gpb_lcd_if.source                        lcd,
	input  logic                             cfg_wr_en,
	input  logic [gpb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gpb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	gpb_pkg::cfg_t cfg_q;

	logic          job_valid;
	logic          job_ready;
	gpb_pkg::job_t job;
	logic          head_valid;
	logic          head_pop;
	gpb_pkg::job_t head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_column <= gpb_pkg::START_COLUMN_RST;
			cfg_q.start_row <= gpb_pkg::START_ROW_RST;
			cfg_q.glyph_width <= gpb_pkg::GLYPH_WIDTH_RST;
			cfg_q.glyph_height <= gpb_pkg::GLYPH_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (gpb_pkg::cfg_reg_t'(cfg_index))
				gpb_pkg::REG_START_COLUMN: begin
					cfg_q.start_column <= cfg_wdata;
				end
				gpb_pkg::REG_START_ROW: begin
					cfg_q.start_row <= cfg_wdata[5:0];
				end
				gpb_pkg::REG_GLYPH_WIDTH: begin
					cfg_q.glyph_width <= cfg_wdata[5:0];
				end
				default: begin
					cfg_q.glyph_height <= cfg_wdata[5:0];
				end
			endcase
		end
	end

	gpb_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.PAGE_COUNT(PAGE_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.glyph    (glyph),
		.cfg      (cfg_q),
		.restart  (cfg_wr_en),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job      (job)
	);

	gpb_job_fifo #(
		.DEPTH(2)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(job_valid),
		.wr_ready(job_ready),
		.wr_job  (job),
		.rd_valid(head_valid),
		.rd_pop  (head_pop),
		.rd_job  (head)
	);

	gpb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.head_pop  (head_pop),
		.lcd       (lcd)
	);

endmodule

>>> hw/rtl/gpb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph page blitter checker
// Port-level checks on the lcd word stream, bound to the top level.
// ----------------------------------------------------------------------------
module gpb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       lcd_valid,
	input logic       lcd_ready,
	input logic [7:0] lcd_out_byte,
	input logic       lcd_is_data,
	input logic       lcd_last
);

	// A word offered and not taken stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		lcd_valid && !lcd_ready |=> lcd_valid)
		else $error("lcd word withdrawn while stalled");

	// A stalled word keeps its byte and its last flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		lcd_valid && !lcd_ready |=> $stable(lcd_out_byte) && $stable(lcd_last))
		else $error("lcd word changed while stalled");

	// Every run ends with its data word, so a command word never closes one.
	assert property (@(posedge clk) disable iff (!arst_n)
		lcd_valid && !lcd_is_data |-> !lcd_last)
		else $error("command word marked last");

	// Command words are column low, column high or page commands only.
	assert property (@(posedge clk) disable iff (!arst_n)
		lcd_valid && !lcd_is_data |->
			(lcd_out_byte[7:5] == 3'b000) || (lcd_out_byte[7:4] == 4'hB))
		else $error("unexpected command code");

	// Nothing is offered while reset is held.
	assert property (@(posedge clk) !arst_n |-> !lcd_valid)
		else $error("lcd word offered during reset");

endmodule

bind glyph_page_blitter_top gpb_checker u_gpb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.lcd_valid   (lcd.valid),
	.lcd_ready   (lcd.ready),
	.lcd_out_byte(lcd.out_byte),
	.lcd_is_data (lcd.is_data),
	.lcd_last    (lcd.last)
);

>>> tb/glyph_page_blitter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph page blitter testbench
// Feeds glyph bytes and register settings into the blitter, predicts the
// controller words in a local model of the page addressing and row merging
// or takes them from the directed table, and compares each word leaving the
// lcd channel in order. A short directed table covers extremes and clipping,
// then random glyphs run under three patterns of idling on both channels.
// ----------------------------------------------------------------------------
module glyph_page_blitter_top_tb;

	localparam int MAX_COLS = 32;
	localparam int PAGES = 8;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS = 100;

	// One controller word as it leaves the lcd channel.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       last;
	} lcd_word_t;

	// One line of the directed table: a register write or a glyph byte.
	typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		gpb_pkg::cfg_reg_t reg_sel;
		logic [7:0]        value;
		logic              typed;
		logic [31:0]       run_words;
	} blit_row_t;

	localparam int N_DIRECTED = 31;

	// Typed runs hold page, column high, column low and data words.
	localparam blit_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'hFF, 1'b1, 32'hB61000FF},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'h00, 1'b1, 32'hB6100100},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'hA5, 1'b1, 32'hB61002A5},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'h5A, 1'b0, 32'h0},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'h80, 1'b0, 32'h0},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'h01, 1'b1, 32'hB6100001},
		'{ROW_CFG,  gpb_pkg::REG_START_COLUMN, 8'hFF, 1'b0, 32'h0},
		'{ROW_CFG,  gpb_pkg::REG_START_ROW,    8'hFF, 1'b0, 32'h0},
		'{ROW_CFG,  gpb_pkg::REG_GLYPH_WIDTH,  8'h01, 1'b0, 32'h0},
		'{ROW_CFG,  gpb_pkg::REG_GLYPH_HEIGHT, 8'h01, 1'b0, 32'h0},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'h01, 1'b1, 32'hB51F0F80},
		'{ROW_CFG,  gpb_pkg::REG_GLYPH_HEIGHT, 8'h09, 1'b0, 32'h0},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'hFF, 1'b1, 32'hB51F0F80},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'hFF, 1'b0, 32'h0},
		'{ROW_CFG,  gpb_pkg::REG_START_ROW,    8'h09, 1'b0, 32'h0},
		'{ROW_CFG,  gpb_pkg::REG_GLYPH_WIDTH,  8'h02, 1'b0, 32'h0},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'h81, 1'b0, 32'h0},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'h7F, 1'b0, 32'h0},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'hC3, 1'b0, 32'h0},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'h3C, 1'b0, 32'h0},
		'{ROW_CFG,  gpb_pkg::REG_GLYPH_WIDTH,  8'h00, 1'b0, 32'h0},
		'{ROW_CFG,  gpb_pkg::REG_GLYPH_HEIGHT, 8'h00, 1'b0, 32'h0},
		'{ROW_CFG,  gpb_pkg::REG_START_ROW,    8'h38, 1'b0, 32'h0},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'hFF, 1'b1, 32'hB51F0FFF},
		'{ROW_CFG,  gpb_pkg::REG_START_COLUMN, 8'h00, 1'b0, 32'h0},
		'{ROW_CFG,  gpb_pkg::REG_GLYPH_WIDTH,  8'hFF, 1'b0, 32'h0},
		'{ROW_CFG,  gpb_pkg::REG_GLYPH_HEIGHT, 8'h20, 1'b0, 32'h0},
		'{ROW_CFG,  gpb_pkg::REG_START_ROW,    8'h14, 1'b0, 32'h0},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'hE7, 1'b0, 32'h0},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'h18, 1'b0, 32'h0},
		'{ROW_BYTE, gpb_pkg::REG_START_COLUMN, 8'h55, 1'b0, 32'h0}
	};

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [gpb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [gpb_pkg::CFG_DATA_W-1:0] cfg_wdata;

	gpb_glyph_if glyph_ch ();
	gpb_lcd_if lcd_ch ();

	glyph_page_blitter_top #(
		.MAX_WIDTH(MAX_COLS),
		.PAGE_COUNT(PAGES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.glyph(glyph_ch),
		.lcd(lcd_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Local copy of the registers and the glyph position.
	logic [7:0] col_origin;
	logic [5:0] row_origin;
	logic [5:0] width_reg;
	logic [5:0] height_reg;
	logic [7:0] row_above [MAX_COLS];
	int unsigned col_pos;
	int unsigned row_pos;

	lcd_word_t fresh_words [$];
	lcd_word_t words_due [$];

	int fail_count;
	int send_idle_pct;
	int recv_idle_pct;
	int send_burst;
	int recv_burst;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog.
	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	// Append one run of four words unless its page lies past the panel.
	function automatic void add_run(int unsigned page, logic [7:0] col, logic [7:0] data);
		logic [7:0] pg8;
		if (page >= PAGES)
			return;
		pg8 = page[7:0];
		fresh_words.push_back('{(page < 2) ? gpb_pkg::PAGE_CMD_LOW + pg8 :
			gpb_pkg::PAGE_CMD_HIGH + pg8, 1'b0, 1'b0});
		fresh_words.push_back('{gpb_pkg::COL_HI_CMD + {4'h0, col[7:4]}, 1'b0, 1'b0});
		fresh_words.push_back('{{4'h0, col[3:0]}, 1'b0, 1'b0});
		fresh_words.push_back('{data, 1'b1, 1'b0});
	endfunction

	// Compute the words that one glyph byte causes and advance the position.
	function automatic void blit_byte(logic [7:0] cur);
		int unsigned width;
		int unsigned rows;
		int unsigned shift;
		int unsigned page;
		logic [7:0] col;
		logic [7:0] prev;
		logic [15:0] wide;
		logic [7:0] data;
		fresh_words.delete();
		width = (width_reg == 0) ? 1 : ((width_reg > MAX_COLS) ? MAX_COLS : width_reg);
		rows = (int'(height_reg) + 7) >> 3;
		if (rows == 0)
			rows = 1;
		if (col_pos >= width || row_pos >= rows) begin
			col_pos = 0;
			row_pos = 0;
		end
		shift = row_origin[2:0];
		page = row_origin[5:3] + row_pos;
		col = col_origin + col_pos[7:0];
		prev = (row_pos > 0 && shift != 0) ? row_above[col_pos] : 8'h00;
		wide = {8'h00, cur} << shift;
		data = wide[7:0] | ((shift != 0) ? (prev >> (8 - shift)) : 8'h00);
		add_run(page, col, data);
		// The last row spills into the page below when the rows are not aligned.
		if (row_pos + 1 == rows && shift != 0)
			add_run(page + 1, col, cur >> (8 - shift));
		row_above[col_pos] = cur;
		col_pos++;
		if (col_pos >= width) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= rows)
				row_pos = 0;
		end
		if (fresh_words.size() > 0)
			fresh_words[fresh_words.size() - 1].last = 1'b1;
	endfunction

	// Write one register; entered and left at a falling edge.
	task automatic write_reg(gpb_pkg::cfg_reg_t sel, logic [7:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= value;
		case (sel)
			gpb_pkg::REG_START_COLUMN: begin
				col_origin = value;
			end
			gpb_pkg::REG_START_ROW: begin
				row_origin = value[5:0];
			end
			gpb_pkg::REG_GLYPH_WIDTH: begin
				width_reg = value[5:0];
			end
			default: begin
				height_reg = value[5:0];
			end
		endcase
		col_pos = 0;
		row_pos = 0;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one glyph word, with random gaps before it, and queue its results.
	task automatic push_glyph_byte(logic [7:0] value, logic typed, logic [31:0] run_words);
		while (send_burst == 0 && $urandom_range(99) < send_idle_pct) begin
			glyph_ch.valid <= 1'b0;
			@(negedge clk);
		end
		if (send_burst > 0)
			send_burst--;
		else if ($urandom_range(99) < 4)
			send_burst = $urandom_range(8, 32);
		glyph_ch.valid <= 1'b1;
		glyph_ch.glyph_byte <= value;
		@(posedge clk);
		while (!glyph_ch.ready)
			@(posedge clk);
		blit_byte(value);
		if (typed) begin
			words_due.push_back('{run_words[31:24], 1'b0, 1'b0});
			words_due.push_back('{run_words[23:16], 1'b0, 1'b0});
			words_due.push_back('{run_words[15:8], 1'b0, 1'b0});
			words_due.push_back('{run_words[7:0], 1'b1, 1'b1});
		end else begin
			foreach (fresh_words[i])
				words_due.push_back(fresh_words[i]);
		end
		@(negedge clk);
	endtask

	// Stop sending, drain every expected word, then let a dropped byte finish.
	task automatic wait_idle();
		glyph_ch.valid <= 1'b0;
		while (words_due.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Random glyphs under one idling pattern.
	task automatic run_phase(int send_pct, int recv_pct);
		int sent;
		int unsigned width;
		int unsigned rows;
		int unsigned glyph_bytes;
		int unsigned count;
		logic [7:0] value;
		sent = 0;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (sent < PHASE_ITEMS) begin
			wait_idle();
			// Column origin, with both ends of the range.
			case ($urandom_range(9))
				0: value = 8'h00;
				1: value = 8'hFF;
				default: value = 8'($urandom);
			endcase
			write_reg(gpb_pkg::REG_START_COLUMN, value);
			// Row origin; the top bits of the write word are don't-care.
			case ($urandom_range(9))
				0: value = {2'($urandom), 6'd0};
				1: value = {2'($urandom), 6'd63};
				2: value = {2'($urandom), 6'($urandom_range(56, 62))};
				default: value = 8'($urandom);
			endcase
			write_reg(gpb_pkg::REG_START_ROW, value);
			// Width: mostly narrow, a few zero, full and over-range.
			case ($urandom_range(19))
				0: value = 8'd0;
				1: value = 8'd32;
				2: value = 8'($urandom_range(33, 63));
				default: value = 8'($urandom_range(1, 8));
			endcase
			write_reg(gpb_pkg::REG_GLYPH_WIDTH, value);
			case ($urandom_range(19))
				0: value = 8'd0;
				1: value = 8'($urandom_range(57, 63));
				2: value = 8'($urandom_range(1, 63));
				default: value = 8'($urandom_range(1, 24));
			endcase
			write_reg(gpb_pkg::REG_GLYPH_HEIGHT, value);
			width = (width_reg == 0) ? 1 : ((width_reg > MAX_COLS) ? MAX_COLS : width_reg);
			rows = (int'(height_reg) + 7) >> 3;
			if (rows == 0)
				rows = 1;
			glyph_bytes = width * rows;
			// Whole glyphs most of the time; sometimes a glyph cut short.
			if ($urandom_range(7) == 0)
				count = $urandom_range(1, glyph_bytes);
			else if (glyph_bytes <= 48)
				count = glyph_bytes * $urandom_range(1, 2);
			else
				count = $urandom_range(8, 48);
			repeat (count) begin
				push_glyph_byte(8'($urandom), 1'b0, 32'h0);
				sent++;
			end
		end
	endtask

	// Receiver: random stalls with occasional runs of steady ready.
	always @(negedge clk) begin
		if (!arst_n) begin
			lcd_ch.ready <= 1'b0;
		end else if (recv_burst > 0) begin
			recv_burst <= recv_burst - 1;
			lcd_ch.ready <= 1'b1;
		end else if ($urandom_range(99) < 3) begin
			recv_burst <= $urandom_range(8, 40);
			lcd_ch.ready <= 1'b1;
		end else begin
			lcd_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each accepted word with the oldest expectation.
	always @(posedge clk) begin
		lcd_word_t want;
		if (arst_n && lcd_ch.valid && lcd_ch.ready) begin
			if (words_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t unexpected word: out_byte %h is_data %b last %b", $realtime,
						lcd_ch.out_byte, lcd_ch.is_data, lcd_ch.last);
			end else begin
				want = words_due.pop_front();
				if (lcd_ch.out_byte !== want.out_byte || lcd_ch.is_data !== want.is_data ||
					lcd_ch.last !== want.last) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t word mismatch: expected %h/%b/%b, got %h/%b/%b",
							$realtime, want.out_byte, want.is_data, want.last,
							lcd_ch.out_byte, lcd_ch.is_data, lcd_ch.last);
				end
			end
		end
	end

	// Main sequence: reset, directed table, three random phases, drain.
	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = gpb_pkg::REG_START_COLUMN;
		cfg_wdata = 8'h00;
		glyph_ch.valid = 1'b0;
		glyph_ch.glyph_byte = 8'h00;
		send_burst = 0;
		send_idle_pct = 31;
		recv_idle_pct = 82;
		col_origin = gpb_pkg::START_COLUMN_RST;
		row_origin = gpb_pkg::START_ROW_RST;
		width_reg = gpb_pkg::GLYPH_WIDTH_RST;
		height_reg = gpb_pkg::GLYPH_HEIGHT_RST;
		col_pos = 0;
		row_pos = 0;
		foreach (row_above[i])
			row_above[i] = 8'h00;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
				if (i > 0 && DIRECTED_ROWS[i - 1].kind == ROW_BYTE)
					wait_idle();
				write_reg(DIRECTED_ROWS[i].reg_sel, DIRECTED_ROWS[i].value);
			end else begin
				push_glyph_byte(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed,
					DIRECTED_ROWS[i].run_words);
			end
		end

		run_phase(31, 82);
		run_phase(82, 31);
		run_phase(0, 0);
		wait_idle();

		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
